// ===== rtl/wssd_pkg.sv =====
// shared constants, types and state codes for the windowed ssd cost unit
`timescale 1ns / 1ps
`default_nettype none
package wssd_pkg;

  localparam int unsigned MaxWidth   = 1024;
  localparam int unsigned MaxWindow  = 31;
  localparam int unsigned PixelBits  = 16;
  localparam int unsigned RingRows   = MaxWindow - 1;
  localparam int unsigned ColBits    = $clog2(MaxWidth);
  localparam int unsigned SlotBits   = $clog2(RingRows);
  localparam int unsigned LineDepth  = RingRows * MaxWidth;
  localparam int unsigned LineAw     = SlotBits + ColBits;
  localparam int unsigned SqBits     = 2 * PixelBits;
  localparam int unsigned ColSumBits = 37;
  localparam int unsigned WinSumBits = 42;
  localparam int unsigned DividBits  = WinSumBits + 8;
  localparam int unsigned DivisBits  = 10;
  localparam int unsigned OutBits    = 40;

  // register indexes of the configuration port
  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegWindow = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_UPDATE,
    ST_WSUM,
    ST_DIV,
    ST_FIN
  } wssd_state_e;

  // request to the divider
  typedef struct packed {
    logic                 start;
    logic [DividBits-1:0] dividend;
    logic [DivisBits-1:0] divisor;
  } div_req_t;

  // answer from the divider
  typedef struct packed {
    logic                 done;
    logic [DividBits-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/windowed_ssd_cost_unit.sv =====
// top level: windowed sum of squared differences over two raster images
//
// channel  direction  signals
// in       input      in_valid_i/in_ready_o, frame_start_i, pixel_a_i, pixel_b_i
// out      output     out_valid_o/out_ready_i, mean_sq_diff_o, center_row_o,
//                     center_col_o, frame_end_o
// cfg      input      cfg_we_i, cfg_index_i, cfg_wdata_i
//
// one pixel pair at a time: while row < span (span = 2*floor(ws/2)) only update;
// once row >= span line-buffer reads, drain, update, window sum (no reads or drain
// when span is 0); a result adds the divider and the load of the output register.
// reset clears counters and window sum and sets the configuration to its defaults;
// memories need no clearing. a waiting result sits in the output register; the next
// transaction is taken meanwhile and stalls only when a new result is ready to replace it.
`timescale 1ns / 1ps
`default_nettype none
module windowed_ssd_cost_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [1:0]                        cfg_index_i,
  input  wire logic [15:0]                       cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              frame_start_i,
  input  wire logic [wssd_pkg::PixelBits-1:0]    pixel_a_i,
  input  wire logic [wssd_pkg::PixelBits-1:0]    pixel_b_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [wssd_pkg::OutBits-1:0]           mean_sq_diff_o,
  output logic [15:0]                            center_row_o,
  output logic [wssd_pkg::ColBits-1:0]           center_col_o,
  output logic                                   frame_end_o
);
  import wssd_pkg::*;

  // configuration
  logic [10:0] cfg_w_q;
  logic [15:0] cfg_h_q;
  logic [4:0]  cfg_ws_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q  <= 11'd640;
      cfg_h_q  <= 16'd480;
      cfg_ws_q <= 5'd5;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegWidth:  cfg_w_q  <= cfg_wdata_i[10:0];
        RegHeight: cfg_h_q  <= cfg_wdata_i;
        RegWindow: cfg_ws_q <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [10:0] eff_w;
  logic [15:0] eff_h;
  logic [4:0]  eff_ws;
  always_comb begin
    eff_w = cfg_w_q;
    if (cfg_w_q == 11'd0) eff_w = 11'd1;
    if (cfg_w_q > 11'(MaxWidth)) eff_w = 11'(MaxWidth);
    eff_h  = (cfg_h_q == 16'd0) ? 16'd1 : cfg_h_q;
    eff_ws = (cfg_ws_q == 5'd0) ? 5'd1 : cfg_ws_q;
  end

  wssd_state_e state_q, state_d;

  // position counters
  logic [15:0]         row_q, row_d;
  logic [ColBits-1:0]  col_q, col_d;
  logic [SlotBits-1:0] slot_q, slot_d;
  logic [WinSumBits-1:0] wsum_q, wsum_d;

  // item registers
  logic [15:0]          it_r_q;
  logic [ColBits-1:0]   it_c_q;
  logic [SlotBits-1:0]  it_slot_q;
  logic [SqBits-1:0]    it_sq_q;
  logic [4:0]           it_span_q, it_hw_q, it_ws_q;
  logic [10:0]          it_w_q;
  logic [15:0]          it_h_q;
  logic                 it_use_q;
  logic [ColSumBits-1:0] acc_q, acc_d;
  logic [4:0]           k_q, k_d;
  logic [SlotBits-1:0]  ptr_q, ptr_d;
  logic                 rd_pend_q;

  // output register
  logic                 ov_q;
  logic [OutBits-1:0]   o_msd_q;
  logic [15:0]          o_row_q;
  logic [ColBits-1:0]   o_col_q;
  logic                 o_end_q;

  logic accept;
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  // accept-time values
  logic [15:0]         a_r;
  logic [ColBits-1:0]  a_c;
  logic [SlotBits-1:0] a_slot;
  logic [PixelBits-1:0] a_d;
  logic [SqBits-1:0]   a_sq;
  logic [4:0]          a_span;
  logic [10:0]         a_c1;
  always_comb begin
    a_r    = frame_start_i ? 16'd0 : row_q;
    a_slot = frame_start_i ? '0 : slot_q;
    a_c    = frame_start_i ? '0 : col_q;
    if ({1'b0, a_c} >= eff_w) a_c = ColBits'(eff_w - 11'd1);
    a_d    = (pixel_a_i >= pixel_b_i) ? pixel_a_i - pixel_b_i : pixel_b_i - pixel_a_i;
    a_sq   = SqBits'(a_d) * SqBits'(a_d);
    a_span = {eff_ws[4:1], 1'b0};
    a_c1   = {1'b0, a_c} + 11'd1;
  end

  // counters advance at accept
  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    slot_d = slot_q;
    if (accept) begin
      if (a_c1 >= eff_w) begin
        col_d = '0;
        if ({1'b0, a_r} + 17'd1 >= {1'b0, eff_h}) begin
          row_d  = '0;
          slot_d = '0;
        end else begin
          row_d  = a_r + 16'd1;
          slot_d = (a_slot == SlotBits'(RingRows - 1)) ? '0 : a_slot + 1'b1;
        end
      end else begin
        col_d  = a_c1[ColBits-1:0];
        row_d  = a_r;
        slot_d = a_slot;
      end
    end
  end

  // line buffer and column sum memories
  logic                  line_we, line_re;
  logic [LineAw-1:0]     line_waddr, line_raddr;
  logic [SqBits-1:0]     line_rdata;
  logic                  cs_we, cs_re;
  logic [ColBits-1:0]    cs_raddr;
  logic [ColSumBits-1:0] cs_rdata;
  logic [10:0]           sub_col;

  wssd_ram #(.Depth(LineDepth), .Width(SqBits), .Aw(LineAw)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_waddr),
    .wdata_i (it_sq_q),
    .re_i    (line_re),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  wssd_ram #(.Depth(MaxWidth), .Width(ColSumBits), .Aw(ColBits)) u_colsum_ram (
    .clk_i   (clk_i),
    .we_i    (cs_we),
    .waddr_i (it_c_q),
    .wdata_i (acc_q),
    .re_i    (cs_re),
    .raddr_i (cs_raddr),
    .rdata_o (cs_rdata)
  );

  // window conditions
  logic [10:0] c_ext;
  logic        sub_en, emit;
  assign c_ext   = {1'b0, it_c_q};
  assign sub_col = c_ext - {6'd0, it_span_q} - 11'd1;
  assign cs_raddr = sub_col[ColBits-1:0];
  assign sub_en  = c_ext >= {6'd0, it_span_q} + 11'd1;
  assign emit    = sub_en && (it_r_q >= {11'd0, it_span_q} + 16'd1)
                   && ({1'b0, it_r_q} + 17'd2 <= {1'b0, it_h_q})
                   && (c_ext + 11'd2 <= it_w_q);

  // divider
  div_req_t div_req;
  div_rsp_t div_rsp;
  wssd_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ((a_r >= {11'd0, a_span}) && (a_span != 5'd0)) ? ST_READ : ST_UPDATE;
        end
      end
      ST_READ:   if (k_q == it_span_q) state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_UPDATE;
      ST_UPDATE: state_d = it_use_q ? ST_WSUM : ST_IDLE;
      ST_WSUM:   state_d = emit ? ST_DIV : ST_IDLE;
      ST_DIV:    if (div_rsp.done) state_d = ST_FIN;
      ST_FIN:    if (!ov_q || out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    acc_d      = acc_q;
    k_d        = k_q;
    ptr_d      = ptr_q;
    wsum_d     = wsum_q;
    line_we    = 1'b0;
    line_re    = 1'b0;
    line_waddr = {it_slot_q, it_c_q};
    line_raddr = {ptr_q, it_c_q};
    cs_we      = 1'b0;
    cs_re      = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {wsum_q, 8'd0};
    div_req.divisor  = DivisBits'(it_ws_q) * DivisBits'(it_ws_q);
    if (rd_pend_q) acc_d = acc_q + ColSumBits'(line_rdata);
    unique case (state_q)
      ST_IDLE: begin
        acc_d = ColSumBits'(a_sq);
        k_d   = 5'd1;
        ptr_d = (a_slot == '0) ? SlotBits'(RingRows - 1) : a_slot - 1'b1;
      end
      ST_READ: begin
        line_re = 1'b1;
        k_d     = k_q + 5'd1;
        ptr_d   = (ptr_q == '0) ? SlotBits'(RingRows - 1) : ptr_q - 1'b1;
      end
      ST_UPDATE: begin
        line_we = 1'b1;
        cs_we   = it_use_q;
        cs_re   = it_use_q && sub_en;
      end
      ST_WSUM: begin
        if (it_c_q == '0) begin
          wsum_d = WinSumBits'(acc_q);
        end else begin
          wsum_d = wsum_q + WinSumBits'(acc_q)
                   - (sub_en ? WinSumBits'(cs_rdata) : '0);
        end
      end
      ST_DIV: begin
        div_req.start = (k_q != 5'd0);
        k_d           = 5'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      row_q     <= '0;
      col_q     <= '0;
      slot_q    <= '0;
      wsum_q    <= '0;
      rd_pend_q <= 1'b0;
      ov_q      <= 1'b0;
      k_q       <= '0;
    end else begin
      state_q   <= state_d;
      row_q     <= row_d;
      col_q     <= col_d;
      slot_q    <= slot_d;
      wsum_q    <= wsum_d;
      rd_pend_q <= line_re;
      k_q       <= (state_q == ST_WSUM) ? 5'd1 : k_d;
      if (state_q == ST_FIN && (!ov_q || out_ready_i)) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    ptr_q <= ptr_d;
    if (accept) begin
      it_r_q    <= a_r;
      it_c_q    <= a_c;
      it_slot_q <= a_slot;
      it_sq_q   <= a_sq;
      it_span_q <= a_span;
      it_hw_q   <= {1'b0, eff_ws[4:1]};
      it_ws_q   <= eff_ws;
      it_w_q    <= eff_w;
      it_h_q    <= eff_h;
      it_use_q  <= a_r >= {11'd0, a_span};
    end
    if (state_q == ST_FIN && (!ov_q || out_ready_i)) begin
      o_msd_q <= (div_rsp.quotient[DividBits-1:OutBits] != '0) ? '1
                 : div_rsp.quotient[OutBits-1:0];
      o_row_q <= it_r_q - {11'd0, it_hw_q};
      o_col_q <= it_c_q - ColBits'(it_hw_q);
      o_end_q <= ({1'b0, it_r_q} + 17'd2 == {1'b0, it_h_q}) && (c_ext + 11'd2 == it_w_q);
    end
  end

  assign out_valid_o    = ov_q;
  assign mean_sq_diff_o = o_msd_q;
  assign center_row_o   = o_row_q;
  assign center_col_o   = o_col_q;
  assign frame_end_o    = o_end_q;

endmodule
`default_nettype wire

// ===== rtl/wssd_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
`timescale 1ns / 1ps
`default_nettype none
module wssd_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 32,
  parameter int unsigned Aw    = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/wssd_divider.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module wssd_divider (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire wssd_pkg::div_req_t req_i,
  output wssd_pkg::div_rsp_t      rsp_o
);
  import wssd_pkg::*;

  localparam int unsigned CntBits = $clog2(DividBits + 1);

  logic [DividBits-1:0] quo_q, quo_d;
  logic [DivisBits:0]   rem_q, rem_d;
  logic [DivisBits-1:0] dvs_q, dvs_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DivisBits+1:0] trial;

  // one shift-and-subtract step
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[DividBits-1]} - {2'b00, dvs_q};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DivisBits+1]) begin
        rem_d = trial[DivisBits:0];
        quo_d = {quo_q[DividBits-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DivisBits-1:0], quo_q[DividBits-1]};
        quo_d = {quo_q[DividBits-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntBits'(DividBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
`default_nettype wire

// ===== rtl/wssd_checker.sv =====
// port-level checker for the windowed ssd cost unit and its bind
`timescale 1ns / 1ps
`default_nettype none
module wssd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [39:0] mean_sq_diff_o,
  input wire logic [15:0] center_row_o,
  input wire logic [9:0]  center_col_o
);

  // a pending result is held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(mean_sq_diff_o))
    else $error("result dropped or changed while stalled");

  // each transaction keeps the unit busy in the cycle after it is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("transaction taken without a busy cycle");

  // a window centre never lies on the first row or column
  a_centre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> center_row_o != 16'd0 && center_col_o != 10'd0)
    else $error("window centre on the image border");

endmodule

bind windowed_ssd_cost_unit wssd_checker u_wssd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .mean_sq_diff_o (mean_sq_diff_o),
  .center_row_o   (center_row_o),
  .center_col_o   (center_col_o)
);
`default_nettype wire
